### rtl/core/rar_pkg.sv
// ---------------------------------------------------------------------------
// rar_pkg
// shared types and codes for the rational arithmetic reduction core
// ---------------------------------------------------------------------------
package rar_pkg;

   localparam int unsigned MAG_W = 33;
   localparam int unsigned PRD_W = 66;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic [1:0]         status;
      logic               a_greater;
      logic               a_equal;
   } rsp_type;

   // classified work handed from front to back
   typedef struct packed {
      logic             neg;
      logic [PRD_W-1:0] n_mag;
      logic [PRD_W-1:0] d_mag;
      logic [1:0]       status;
      logic             a_greater;
      logic             a_equal;
   } job_type;

endpackage

### rtl/core/rar_front.sv
// ---------------------------------------------------------------------------
// rar_front
// operand decode, cross products and classification, one product per cycle
// ---------------------------------------------------------------------------
module rar_front
   import rar_pkg::*;
#(
   parameter int unsigned W = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job_out
);

   typedef enum logic [2:0] {F_IDLE, F_P0, F_P1, F_P2, F_P3, F_DONE} fstate_type;

   fstate_type       state_ff;
   logic [1:0]       op_ff;
   logic             an_neg_ff, bn_neg_ff;
   logic [MAG_W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [PRD_W-1:0] l_ff, r_ff, x_ff;
   logic             zden_ff;
   job_type          job_ff;

   function automatic logic [MAG_W:0] rd_op(input logic [31:0] raw);
      logic [31:0]      x;
      logic             s;
      logic [MAG_W-1:0] m;
      begin
         x = raw;
         if (W < 32) x = raw & ((32'd1 << W) - 32'd1);
         s = x[W-1];
         if (s) m = (MAG_W'(1) << W) - MAG_W'(x);
         else m = MAG_W'(x);
         rd_op = {s, m};
      end
   endfunction

   logic [MAG_W:0] oan, oad, obn, obd;
   assign oan = rd_op(in_item.a_num);
   assign oad = rd_op(in_item.a_den);
   assign obn = rd_op(in_item.b_num);
   assign obd = rd_op(in_item.b_den);

   // one multiplier, shared by the product states F_P0 to F_P3
   logic [MAG_W-1:0] mx, my;
   logic [PRD_W-1:0] prod;
   always_comb begin
      case (state_ff)
         F_P0: begin mx = an_ff; my = bd_ff; end
         F_P1: begin mx = bn_ff; my = ad_ff; end
         F_P2: begin
            mx = (op_ff == OP_MUL) ? an_ff : an_ff;
            my = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         F_P3: begin
            mx = ad_ff;
            my = (op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
         default: begin mx = '0; my = '0; end
      endcase
   end
   assign prod = PRD_W'(mx) * PRD_W'(my);

   assign in_ready  = (state_ff == F_IDLE);
   assign job_valid = (state_ff == F_DONE);
   assign job_out   = job_ff;

   logic ln, rn, rsn;
   logic [PRD_W:0] lv, rv;
   always_comb begin
      ln  = an_neg_ff && (l_ff != '0);
      rn  = bn_neg_ff && (r_ff != '0);
      lv  = ln ? -{1'b0, l_ff} : {1'b0, l_ff};
      rv  = rn ? -{1'b0, r_ff} : {1'b0, r_ff};
      rsn = (op_ff == OP_SUB) ? !rn : rn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: if (in_valid) begin
               op_ff     <= in_item.op;
               an_ff     <= oan[MAG_W-1:0];
               ad_ff     <= oad[MAG_W-1:0];
               bn_ff     <= obn[MAG_W-1:0];
               bd_ff     <= obd[MAG_W-1:0];
               an_neg_ff <= (oan[MAG_W-1:0] != '0) && (oan[MAG_W] != oad[MAG_W]);
               bn_neg_ff <= (obn[MAG_W-1:0] != '0) && (obn[MAG_W] != obd[MAG_W]);
               zden_ff   <= (oad[MAG_W-1:0] == '0) || (obd[MAG_W-1:0] == '0);
               state_ff  <= F_P0;
            end
            F_P0: begin l_ff <= prod; state_ff <= F_P1; end
            F_P1: begin r_ff <= prod; state_ff <= F_P2; end
            F_P2: begin x_ff <= prod; state_ff <= F_P3; end
            F_P3: begin
               job_ff.a_greater <= !zden_ff && ($signed(lv) > $signed(rv));
               job_ff.a_equal   <= !zden_ff && (lv == rv);
               job_ff.d_mag     <= prod;
               if (op_ff == OP_ADD || op_ff == OP_SUB) begin
                  if (ln == rsn) begin
                     job_ff.n_mag <= l_ff + r_ff;
                     job_ff.neg   <= ln && ((l_ff + r_ff) != '0);
                  end else if (l_ff >= r_ff) begin
                     job_ff.n_mag <= l_ff - r_ff;
                     job_ff.neg   <= ln && (l_ff != r_ff);
                  end else begin
                     job_ff.n_mag <= r_ff - l_ff;
                     job_ff.neg   <= rsn;
                  end
               end else if (op_ff == OP_MUL) begin
                  job_ff.n_mag <= x_ff;
                  job_ff.neg   <= (x_ff != '0) && (an_neg_ff != bn_neg_ff);
               end else begin
                  job_ff.n_mag <= x_ff;
                  job_ff.neg   <= (x_ff != '0) && (an_neg_ff != bn_neg_ff);
               end
               if (zden_ff) job_ff.status <= ST_ZERO_DEN;
               else if (op_ff == OP_DIV && bn_ff == '0) job_ff.status <= ST_DIV_ZERO;
               else job_ff.status <= ST_OK;
               state_ff <= F_DONE;
            end
            F_DONE: if (job_ready) state_ff <= F_IDLE;
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

### rtl/core/rar_queue.sv
// ---------------------------------------------------------------------------
// rar_queue
// two-entry queue between the front and the back
// ---------------------------------------------------------------------------
module rar_queue
   import rar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  job_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output job_type rd_data
);

   job_type    mem [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) mem[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
   end

endmodule

### rtl/core/rar_back.sv
// ---------------------------------------------------------------------------
// rar_back
// euclidean gcd, two divisions by the gcd and the range check
// ---------------------------------------------------------------------------
module rar_back
   import rar_pkg::*;
#(
   parameter int unsigned W = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job_in,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_item
);

   localparam int unsigned CW = $clog2(PRD_W + 1);

   typedef enum logic [2:0] {B_IDLE, B_GCD, B_DIVN, B_DIVD, B_CHK, B_OUT} bstate_type;

   bstate_type       state_ff;
   job_type          job_ff;
   logic [PRD_W-1:0] x_ff, y_ff, g_ff, rn_ff, rd_ff;
   // shared restoring divider: num / den, one quotient bit a cycle
   logic [PRD_W-1:0] dn_ff, dd_ff, q_ff, rem_ff;
   logic [CW-1:0]    cnt_ff;
   logic             dgcd_ff;
   rsp_type          rsp_ff;

   logic [PRD_W:0]   trial;
   logic [PRD_W-1:0] rsh;
   assign rsh   = {rem_ff[PRD_W-2:0], dn_ff[PRD_W-1]};
   assign trial = {rem_ff[PRD_W-1], rsh} - {1'b0, dd_ff};

   logic [PRD_W-1:0] lim;
   assign lim = PRD_W'(1) << (W - 1);

   assign job_ready = (state_ff == B_IDLE);
   assign out_valid = (state_ff == B_OUT);
   assign out_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         case (state_ff)
            B_IDLE: if (job_valid) begin
               job_ff <= job_in;
               if (job_in.status != ST_OK) begin
                  rsp_ff.res_num   <= '0;
                  rsp_ff.res_den   <= '0;
                  rsp_ff.status    <= job_in.status;
                  rsp_ff.a_greater <= job_in.a_greater;
                  rsp_ff.a_equal   <= job_in.a_equal;
                  state_ff <= B_OUT;
               end else begin
                  x_ff <= job_in.n_mag;
                  y_ff <= job_in.d_mag;
                  dgcd_ff <= 1'b1;
                  cnt_ff <= '0;
                  state_ff <= B_GCD;
               end
            end
            B_GCD: begin
               // one x mod y per pass of the divider
               if (y_ff == '0) begin
                  g_ff <= (x_ff == '0) ? PRD_W'(1) : x_ff;
                  dn_ff <= job_ff.n_mag;
                  dd_ff <= (x_ff == '0) ? PRD_W'(1) : x_ff;
                  rem_ff <= '0; q_ff <= '0; cnt_ff <= '0;
                  state_ff <= B_DIVN;
               end else if (cnt_ff == '0 && dgcd_ff) begin
                  dn_ff <= x_ff; dd_ff <= y_ff; rem_ff <= '0; q_ff <= '0;
                  cnt_ff <= CW'(PRD_W); dgcd_ff <= 1'b0;
               end else if (cnt_ff != '0) begin
                  dn_ff <= dn_ff << 1;
                  if (!trial[PRD_W]) rem_ff <= trial[PRD_W-1:0];
                  else rem_ff <= rsh;
                  cnt_ff <= cnt_ff - CW'(1);
               end else begin
                  x_ff <= y_ff; y_ff <= rem_ff; dgcd_ff <= 1'b1;
               end
            end
            B_DIVN, B_DIVD: begin
               if (cnt_ff != CW'(PRD_W)) begin
                  dn_ff <= dn_ff << 1;
                  q_ff  <= {q_ff[PRD_W-2:0], !trial[PRD_W]};
                  if (!trial[PRD_W]) rem_ff <= trial[PRD_W-1:0];
                  else rem_ff <= rsh;
                  cnt_ff <= cnt_ff + CW'(1);
               end else if (state_ff == B_DIVN) begin
                  rn_ff <= q_ff;
                  dn_ff <= job_ff.d_mag; dd_ff <= g_ff;
                  rem_ff <= '0; q_ff <= '0; cnt_ff <= '0;
                  state_ff <= B_DIVD;
               end else begin
                  rd_ff <= q_ff;
                  state_ff <= B_CHK;
               end
            end
            B_CHK: begin
               rsp_ff.a_greater <= job_ff.a_greater;
               rsp_ff.a_equal   <= job_ff.a_equal;
               if (rd_ff > lim - PRD_W'(1) ||
                   (job_ff.neg ? (rn_ff > lim) : (rn_ff > lim - PRD_W'(1)))) begin
                  rsp_ff.res_num <= '0;
                  rsp_ff.res_den <= '0;
                  rsp_ff.status  <= ST_OVERFLOW;
               end else begin
                  rsp_ff.res_num <= job_ff.neg ? -rn_ff[31:0] : rn_ff[31:0];
                  rsp_ff.res_den <= rd_ff[30:0];
                  rsp_ff.status  <= ST_OK;
               end
               state_ff <= B_OUT;
            end
            B_OUT: if (out_ready) state_ff <= B_IDLE;
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

### rtl/core/rational_arith_reduce_core.sv
// ---------------------------------------------------------------------------
// rational_arith_reduce_core
// signed fraction add, subtract, multiply and divide with gcd reduction
// ---------------------------------------------------------------------------
// usage: write an item with req_push while req_full is low; read results
// while rsp_empty is low, taking each with rsp_pop.
// the front decodes operands and forms the cross products on one shared
// 33x33 multiplier, then hands a classified job through a two-entry queue
// to the back.
// the back runs a euclidean gcd on a 66-bit restoring divider, one quotient
// bit a cycle, then two more passes of the same divider for numerator and
// denominator, so the time an item takes depends on the gcd step count.
// errors (zero denominator, divide by zero) skip the divider.
// the front can take the next item while the back is busy.
// reset clears all control state; nothing is in flight afterwards.
// a stalled receiver holds the result; the queue then fills and req_full
// rises.
// ---------------------------------------------------------------------------
module rational_arith_reduce_core
   import rar_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   // effective operand width, held in the legal range
   localparam int unsigned W = (WIDTH < 8) ? 8 : ((WIDTH > 32) ? 32 : WIDTH);

   logic    in_ready;
   logic    fj_valid, fj_ready, bj_valid, bj_ready, out_valid;
   job_type fj, bj;

   assign req_full  = !in_ready;
   assign rsp_empty = !out_valid;

   rar_front #(.W(W)) u_front (
      .clock, .reset,
      .in_valid (req_push), .in_ready, .in_item (req_data),
      .job_valid (fj_valid), .job_ready (fj_ready), .job_out (fj)
   );

   rar_queue u_queue (
      .clock, .reset,
      .wr_valid (fj_valid), .wr_ready (fj_ready), .wr_data (fj),
      .rd_valid (bj_valid), .rd_ready (bj_ready), .rd_data (bj)
   );

   rar_back #(.W(W)) u_back (
      .clock, .reset,
      .job_valid (bj_valid), .job_ready (bj_ready), .job_in (bj),
      .out_valid, .out_ready (rsp_pop), .out_item (rsp_data)
   );

   // an error result always carries a zero fraction
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_OK) |->
         (rsp_data.res_num == '0 && rsp_data.res_den == '0))
      else $error("error result not zero");

   // an ok result has a nonzero denominator
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == ST_OK) |-> (rsp_data.res_den != '0))
      else $error("ok result with zero denominator");

   // greater and equal never both set
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_data.a_greater && rsp_data.a_equal))
      else $error("compare flags conflict");

endmodule

### tb/sv/tb_rational_arith_reduce_core.sv
// ---------------------------------------------------------------------------
// tb_rational_arith_reduce_core
// self-checking bench: directed corners then random fractions, each result
// compared against a behavioural predictor of fraction arithmetic with gcd
// ---------------------------------------------------------------------------
module tb_rational_arith_reduce_core;
   import rar_pkg::*;

   localparam int unsigned WIDTH = 32;
   localparam int unsigned WD_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   rsp_type expected_q[$];
   int      fail_count;
   int      idle_send_pct;
   int      stall_recv_pct;
   int      quiet_cycles;

   rational_arith_reduce_core #(.WIDTH(WIDTH)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sign and magnitude of one WIDTH-bit operand field
   function automatic void split_operand(input logic [31:0] raw, output logic neg,
                                         output logic [65:0] mag);
      logic [32:0] x;
      begin
         x = {1'b0, raw};
         neg = raw[WIDTH-1];
         mag = neg ? 66'((33'd1 << WIDTH) - x) : 66'(x);
      end
   endfunction

   // signed sum of two sign-magnitude values
   function automatic void sm_add(input logic xn, input logic [65:0] xm, input logic yn,
                                  input logic [65:0] ym, output logic rn,
                                  output logic [65:0] rm);
      begin
         if (xn == yn) begin
            rm = xm + ym; rn = xn;
         end else if (xm >= ym) begin
            rm = xm - ym; rn = xn;
         end else begin
            rm = ym - xm; rn = yn;
         end
         if (rm == 0) rn = 1'b0;
      end
   endfunction

   function automatic rsp_type predict_fraction(req_type rq);
      rsp_type rs;
      logic an_n, ad_n, bn_n, bd_n, l_n, r_n, n_n, tmp_n;
      logic [65:0] an_m, ad_m, bn_m, bd_m, l_m, r_m, n_m, d_m, g, x, y, t, q_n, q_d;
      logic signed [67:0] lv, rv;
      logic [65:0] lim;
      begin
         rs = '0;
         lim = 66'd1 << (WIDTH - 1);
         split_operand(rq.a_num, an_n, an_m);
         split_operand(rq.a_den, ad_n, ad_m);
         split_operand(rq.b_num, bn_n, bn_m);
         split_operand(rq.b_den, bd_n, bd_m);
         if (ad_m == 0 || bd_m == 0) begin
            rs.status = ST_ZERO_DEN;
            return rs;
         end
         // fold denominator signs into numerators
         an_n = (an_m != 0) && (an_n != ad_n);
         bn_n = (bn_m != 0) && (bn_n != bd_n);
         l_m = an_m * bd_m; l_n = (l_m != 0) && an_n;
         r_m = bn_m * ad_m; r_n = (r_m != 0) && bn_n;
         lv = l_n ? -$signed({2'b0, l_m}) : $signed({2'b0, l_m});
         rv = r_n ? -$signed({2'b0, r_m}) : $signed({2'b0, r_m});
         rs.a_greater = lv > rv;
         rs.a_equal = lv == rv;
         d_m = ad_m * bd_m;
         case (op_type'(rq.op))
            OP_ADD: sm_add(l_n, l_m, r_n, r_m, n_n, n_m);
            OP_SUB: begin
               tmp_n = (r_m != 0) && !r_n;
               sm_add(l_n, l_m, tmp_n, r_m, n_n, n_m);
            end
            OP_MUL: begin
               n_m = an_m * bn_m; n_n = (n_m != 0) && (an_n != bn_n);
            end
            default: begin
               if (bn_m == 0) begin
                  rs.status = ST_DIV_ZERO;
                  return rs;
               end
               n_m = an_m * bd_m;
               d_m = ad_m * bn_m;
               n_n = (n_m != 0) && (an_n != bn_n);
            end
         endcase
         x = n_m; y = d_m;
         while (y != 0) begin
            t = x % y; x = y; y = t;
         end
         g = (x == 0) ? 66'd1 : x;
         q_n = n_m / g;
         q_d = d_m / g;
         if (q_d > lim - 1 || (n_n ? (q_n > lim) : (q_n > lim - 1))) begin
            rs.status = ST_OVERFLOW;
            return rs;
         end
         rs.res_num = n_n ? -q_n[31:0] : q_n[31:0];
         rs.res_den = q_d[30:0];
         rs.status = ST_OK;
         return rs;
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      begin
         $display("mismatch %s: got %0h expected %0h", what, got, want);
         fail_count++;
      end
   endtask

   // result checker and receiver stall, sampled at each rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected item", 64'(rsp_data), 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.res_num !== want.res_num)
                  report_mismatch("res_num", 64'(rsp_data.res_num), 64'(want.res_num));
               if (rsp_data.res_den !== want.res_den)
                  report_mismatch("res_den", 64'(rsp_data.res_den), 64'(want.res_den));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.a_greater !== want.a_greater)
                  report_mismatch("a_greater", 64'(rsp_data.a_greater),
                                  64'(want.a_greater));
               if (rsp_data.a_equal !== want.a_equal)
                  report_mismatch("a_equal", 64'(rsp_data.a_equal), 64'(want.a_equal));
            end
         end
         rsp_pop <= ($urandom_range(99) >= stall_recv_pct);
      end
   end

   // watchdog on cycles with no accepted item on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("tb_rational_arith_reduce_core failed");
            $finish;
         end
      end
   end

   // send one item, holding push until accepted; push stays high afterwards
   task automatic send_item(req_type rq);
      begin
         while ($urandom_range(99) < idle_send_pct) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
         req_push <= 1'b1;
         req_data <= rq;
         expected_q.push_back(predict_fraction(rq));
         @(posedge clock);
         while (req_full) @(posedge clock);
      end
   endtask

   // push stays high between items; lowered in idle gaps and when nothing follows
   task automatic send_op(op_type op, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
      req_type rq;
      begin
         rq.op = op; rq.a_num = an; rq.a_den = ad; rq.b_num = bn; rq.b_den = bd;
         send_item(rq);
      end
   endtask

   task automatic wait_drained();
      begin
         req_push <= 1'b0;
         while (expected_q.size() != 0) @(posedge clock);
      end
   endtask

   // random operand: small values mostly, so gcd reduction is common
   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0:       return $urandom;
         1:       return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
         2:       return 32'($signed($urandom_range(20)) - 10);
         default: return 32'($signed($urandom_range(2000)) - 1000);
      endcase
   endfunction

   task automatic test_directed();
      begin
         idle_send_pct = 0; stall_recv_pct = 0;
         for (int o = 0; o < 4; o++) begin
            send_op(op_type'(o), 32'd1, 32'd2, 32'd1, 32'd3);
         end
         // zero denominators on either side
         send_op(OP_ADD, 32'd5, 32'd0, 32'd1, 32'd1);
         send_op(OP_MUL, 32'd5, 32'd1, 32'd1, 32'd0);
         // divide by zero fraction
         send_op(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd7);
         // overflow
         send_op(OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
         send_op(OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
         // most negative operands, negative denominators
         send_op(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'hffff_ffff);
         send_op(OP_SUB, 32'd3, 32'h8000_0000, 32'hffff_fffd, 32'h7fff_ffff);
         send_op(OP_MUL, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
         send_op(OP_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
         // zero result and equal operands
         send_op(OP_SUB, 32'd2, 32'd4, 32'd1, 32'd2);
         send_op(OP_MUL, 32'd0, 32'hffff_fff9, 32'd9, 32'd4);
         send_op(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
         send_op(OP_DIV, 32'hffff_ffff, 32'd1, 32'hffff_ffff, 32'hffff_ffff);
         send_op(OP_SUB, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
      end
   endtask

   task automatic test_random(int count, int send_pct, int recv_pct);
      begin
         idle_send_pct = send_pct; stall_recv_pct = recv_pct;
         repeat (count) begin
            send_op(op_type'($urandom_range(3)), rand_operand(), rand_operand(),
                    rand_operand(), rand_operand());
         end
      end
   endtask

   initial begin
      clock = 1'b0; reset = 1'b1;
      req_push = 1'b0; req_data = '0; rsp_pop = 1'b0;
      fail_count = 0; idle_send_pct = 0; stall_recv_pct = 0; quiet_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(140, 0, 0);
      // sender holds off until every expected item is back
      wait_drained();
      test_random(140, 55, 0);
      test_random(140, 0, 55);
      test_random(130, 15, 15);
      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("tb_rational_arith_reduce_core passed");
      else $display("tb_rational_arith_reduce_core failed");
      $finish;
   end

endmodule
